@@ rtl/pfr_pkg.sv @@
// package for the presence frame receiver: frame constants, codes and payload types
package pfr_pkg;

  // frame geometry (valid range 7 to 32)
  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned PosW        = $clog2(FRAME_BYTES);

  // fixed byte values
  localparam logic [7:0] SYNC0         = 8'hAA;
  localparam logic [7:0] SYNC1         = 8'h55;
  localparam logic [7:0] TYPE_PRESENCE = 8'h01;
  localparam logic [7:0] PRES_ABSENT   = 8'h00;
  localparam logic [7:0] PRES_PRESENT  = 8'h01;

  // input kinds
  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_TIMEOUT = 1'b1
  } kind_e;

  // frame check status
  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_CHECKSUM  = 3'd1,
    ST_BAD_MAGIC = 3'd2,
    ST_BAD_TYPE  = 3'd3,
    ST_PRIVACY   = 3'd4
  } status_e;

  // presence codes
  typedef enum logic [1:0] {
    PR_ABSENT    = 2'd0,
    PR_PRESENT   = 2'd1,
    PR_NO_SENSOR = 2'd2
  } presence_e;

  // input transaction
  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  presence;
    logic [7:0]  confidence;
    logic [31:0] frame_total;
    logic        violations;
    logic        disabled;
  } out_item_t;

endpackage

@@ rtl/presence_frame_receiver.sv @@
// top level of the presence frame receiver: sync hunt, frame capture, check and result skid
//
// Accepts one transaction per cycle while in_stall_o is low: a received byte or a receive
// timeout. The receiver hunts for the sync pair 0xAA 0x55, then captures the rest of a
// FRAME_BYTES frame while keeping a running XOR, so the frame is checked as its last byte
// is accepted and the result is registered. A stall on the result side is absorbed by a
// two-entry output/skid register, and input stall rises only when both entries hold
// results. A frame that passes the checksum, sync and type checks with the vital-sign
// flag set disables the receiver until reset; later inputs are taken but ignored.
module presence_frame_receiver (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pfr_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pfr_pkg::out_item_t  out_data_o
);
  import pfr_pkg::*;

  localparam logic [PosW-1:0] PosSync0 = PosW'(0);
  localparam logic [PosW-1:0] PosSync1 = PosW'(1);
  localparam logic [PosW-1:0] PosType  = PosW'(2);
  localparam logic [PosW-1:0] PosFlags = PosW'(3);
  localparam logic [PosW-1:0] PosPres  = PosW'(4);
  localparam logic [PosW-1:0] PosConf  = PosW'(5);
  localparam logic [PosW-1:0] PosLast  = PosW'(FRAME_BYTES - 1);

  // control and running state
  logic [PosW-1:0] pos_q, pos_d;
  logic [1:0]      presence_q, presence_d;
  logic [7:0]      conf_q, conf_d;
  logic [31:0]     total_q, total_d;
  logic            viol_q, viol_d;
  logic            dis_q, dis_d;

  // captured frame bytes and running checksum
  logic [7:0] xor_q, xor_d;
  logic [7:0] sync0_q, sync0_d;
  logic [7:0] sync1_q, sync1_d;
  logic [7:0] type_q, type_d;
  logic [7:0] flags_q, flags_d;
  logic [7:0] pres_q, pres_d;
  logic [7:0] confb_q, confb_d;

  // result staging
  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_q, out_d, skid_q, skid_d;

  logic      accept;
  logic      res_valid;
  out_item_t res;
  status_e   status;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // frame check on the last byte, priority order
  always_comb begin
    if (xor_q != in_data_i.rx_byte) begin
      status = ST_CHECKSUM;
    end else if (sync0_q != SYNC0 || sync1_q != SYNC1) begin
      status = ST_BAD_MAGIC;
    end else if (type_q != TYPE_PRESENCE) begin
      status = ST_BAD_TYPE;
    end else if (flags_q[0]) begin
      status = ST_PRIVACY;
    end else begin
      status = ST_ACCEPTED;
    end
  end

  // next state of the receiver
  always_comb begin
    pos_d      = pos_q;
    presence_d = presence_q;
    conf_d     = conf_q;
    total_d    = total_q;
    viol_d     = viol_q;
    dis_d      = dis_q;
    xor_d      = xor_q;
    sync0_d    = sync0_q;
    sync1_d    = sync1_q;
    type_d     = type_q;
    flags_d    = flags_q;
    pres_d     = pres_q;
    confb_d    = confb_q;
    res_valid  = 1'b0;

    if (accept && !dis_q) begin
      if (in_data_i.kind == KIND_TIMEOUT) begin
        if (pos_q != PosSync0 && pos_q != PosSync1) begin
          pos_d = PosSync0;
        end
      end else if (pos_q == PosSync0) begin
        if (in_data_i.rx_byte == SYNC0) begin
          sync0_d = in_data_i.rx_byte;
          xor_d   = in_data_i.rx_byte;
          pos_d   = PosSync1;
        end
      end else if (pos_q == PosSync1) begin
        if (in_data_i.rx_byte == SYNC1) begin
          sync1_d = in_data_i.rx_byte;
          xor_d   = xor_q ^ in_data_i.rx_byte;
          pos_d   = PosType;
        end else if (in_data_i.rx_byte == SYNC0) begin
          // sync restart keeps this byte as the first sync byte
          sync0_d = in_data_i.rx_byte;
          xor_d   = in_data_i.rx_byte;
          pos_d   = PosSync1;
        end else begin
          pos_d = PosSync0;
        end
      end else if (pos_q == PosLast) begin
        pos_d     = PosSync0;
        res_valid = 1'b1;
        if (status == ST_PRIVACY) begin
          viol_d     = 1'b1;
          dis_d      = 1'b1;
          presence_d = PR_NO_SENSOR;
        end else if (status == ST_ACCEPTED) begin
          if (pres_q == PRES_ABSENT) begin
            presence_d = PR_ABSENT;
          end else if (pres_q == PRES_PRESENT) begin
            presence_d = PR_PRESENT;
          end else begin
            presence_d = PR_NO_SENSOR;
          end
          conf_d  = confb_q;
          total_d = total_q + 32'd1;
        end
      end else begin
        // capture a body byte
        xor_d = xor_q ^ in_data_i.rx_byte;
        pos_d = pos_q + PosW'(1);
        if (pos_q == PosType)  type_d  = in_data_i.rx_byte;
        if (pos_q == PosFlags) flags_d = in_data_i.rx_byte;
        if (pos_q == PosPres)  pres_d  = in_data_i.rx_byte;
        if (pos_q == PosConf)  confb_d = in_data_i.rx_byte;
      end
    end
  end

  // result transaction built from the updated state
  always_comb begin
    res.status      = status;
    res.presence    = presence_d;
    res.confidence  = conf_d;
    res.frame_total = total_d;
    res.violations  = viol_d;
    res.disabled    = dis_d;
  end

  // output register and skid entry
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q) begin
      out_valid_d = res_valid;
      out_d       = res;
    end else if (!out_stall_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = res_valid;
        skid_d       = res;
      end else begin
        out_valid_d = res_valid;
        out_d       = res;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_d       = res;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= PosSync0;
      presence_q   <= PR_NO_SENSOR;
      conf_q       <= 8'd0;
      total_q      <= 32'd0;
      viol_q       <= 1'b0;
      dis_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      presence_q   <= presence_d;
      conf_q       <= conf_d;
      total_q      <= total_d;
      viol_q       <= viol_d;
      dis_q        <= dis_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    xor_q   <= xor_d;
    sync0_q <= sync0_d;
    sync1_q <= sync1_d;
    type_q  <= type_d;
    flags_q <= flags_d;
    pres_q  <= pres_d;
    confb_q <= confb_d;
    out_q   <= out_d;
    skid_q  <= skid_d;
  end

endmodule

@@ bench/presence_frame_receiver_tb.sv @@
// self-checking testbench for the presence frame receiver: byte stream driver, result monitor
module presence_frame_receiver_tb;
  import pfr_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned RandomItems   = 1000;

  // clock, reset and block ports
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // stimulus and expected results
  in_item_t  rx_stream_q[$];
  out_item_t frame_results_q[$];
  out_item_t want;

  // receiver state as predicted
  int unsigned hunt_pos;
  logic [7:0]  frame_buf [FRAME_BYTES];
  presence_e   cur_presence;
  logic [7:0]  cur_conf;
  logic [31:0] frame_total;
  logic        viol_seen;
  logic        rx_disabled;

  // bookkeeping
  int unsigned in_accepted;
  int unsigned timeouts_sent;
  int unsigned results_checked;
  int unsigned status_seen [5];
  int unsigned fail_count;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned quiet_cycles;
  int unsigned queued_items;

  always #10 clk_i = ~clk_i;

  presence_frame_receiver u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // predicted response to one accepted transaction
  task automatic decode_rx_item(input in_item_t it);
    out_item_t  res;
    logic [7:0] sum;
    status_e    st;
    if (rx_disabled) return;
    if (it.kind == KIND_TIMEOUT) begin
      // only a capture in progress is dropped
      if (hunt_pos >= 2) hunt_pos = 0;
      return;
    end
    if (hunt_pos == 0) begin
      if (it.rx_byte == SYNC0) begin
        frame_buf[0] = it.rx_byte;
        hunt_pos = 1;
      end
      return;
    end
    if (hunt_pos == 1) begin
      if (it.rx_byte == SYNC1) begin
        frame_buf[1] = it.rx_byte;
        hunt_pos = 2;
      end else if (it.rx_byte == SYNC0) begin
        frame_buf[0] = it.rx_byte;
      end else begin
        hunt_pos = 0;
      end
      return;
    end
    frame_buf[hunt_pos] = it.rx_byte;
    hunt_pos++;
    if (hunt_pos < FRAME_BYTES) return;

    // full frame: check in priority order
    hunt_pos = 0;
    sum = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum ^= frame_buf[i];
    if (sum != frame_buf[FRAME_BYTES-1]) begin
      st = ST_CHECKSUM;
    end else if (frame_buf[0] != SYNC0 || frame_buf[1] != SYNC1) begin
      st = ST_BAD_MAGIC;
    end else if (frame_buf[2] != TYPE_PRESENCE) begin
      st = ST_BAD_TYPE;
    end else if (frame_buf[3][0]) begin
      st = ST_PRIVACY;
      viol_seen = 1'b1;
      rx_disabled = 1'b1;
      cur_presence = PR_NO_SENSOR;
    end else begin
      st = ST_ACCEPTED;
      if (frame_buf[4] == PRES_ABSENT) begin
        cur_presence = PR_ABSENT;
      end else if (frame_buf[4] == PRES_PRESENT) begin
        cur_presence = PR_PRESENT;
      end else begin
        cur_presence = PR_NO_SENSOR;
      end
      cur_conf = frame_buf[5];
      frame_total = frame_total + 32'd1;
    end
    res.status      = st;
    res.presence    = cur_presence;
    res.confidence  = cur_conf;
    res.frame_total = frame_total;
    res.violations  = viol_seen;
    res.disabled    = rx_disabled;
    frame_results_q.push_back(res);
  endtask

  // idle mix follows the number of transactions taken so far
  function automatic int unsigned idle_phase();
    return (in_accepted / 128) % 4;
  endfunction

  function automatic int unsigned sender_idle_pct();
    if (hold_left > 0) return 0;
    case (idle_phase())
      1: return 60;
      3: return 30;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned recv_stall_pct();
    case (idle_phase())
      2: return 60;
      3: return 30;
      default: return 0;
    endcase
  endfunction

  // stimulus building
  task automatic push_rx(input kind_e k, input logic [7:0] b);
    in_item_t it;
    it.kind    = k;
    it.rx_byte = b;
    rx_stream_q.push_back(it);
    queued_items++;
  endtask

  task automatic queue_frame(input logic [7:0] typ, input logic [7:0] flg,
                             input logic [7:0] pres, input logic [7:0] conf,
                             input bit bad_sum);
    logic [7:0] fb [FRAME_BYTES];
    logic [7:0] sum;
    fb[0] = SYNC0;
    fb[1] = SYNC1;
    fb[2] = typ;
    fb[3] = flg;
    fb[4] = pres;
    fb[5] = conf;
    for (int i = 6; i < FRAME_BYTES - 1; i++) fb[i] = 8'($urandom);
    sum = '0;
    for (int i = 0; i < FRAME_BYTES - 1; i++) sum ^= fb[i];
    if (bad_sum) sum ^= 8'($urandom_range(255, 1));
    fb[FRAME_BYTES-1] = sum;
    foreach (fb[i]) push_rx(KIND_BYTE, fb[i]);
  endtask

  // wait until the stream is sent and every expected result has arrived
  task automatic drain();
    while (rx_stream_q.size() != 0 || in_valid_i || frame_results_q.size() != 0)
      @(posedge clk_i);
  endtask

  // input driver and predictor hook
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_rx_item(in_data_i);
        in_accepted++;
        if (in_data_i.kind == KIND_TIMEOUT) timeouts_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (rx_stream_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          in_data_i  <= rx_stream_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (frame_results_q.size() == 0) begin
          $error("unexpected result transaction: status %0d", out_data_o.status);
          fail_count++;
        end else begin
          want = frame_results_q.pop_front();
          if (out_data_o.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            fail_count++;
          end
          if (out_data_o.presence != want.presence) begin
            $error("presence: expected %0d, got %0d", want.presence, out_data_o.presence);
            fail_count++;
          end
          if (out_data_o.confidence != want.confidence) begin
            $error("confidence: expected %0d, got %0d", want.confidence,
                   out_data_o.confidence);
            fail_count++;
          end
          if (out_data_o.frame_total != want.frame_total) begin
            $error("frame_total: expected %0d, got %0d", want.frame_total,
                   out_data_o.frame_total);
            fail_count++;
          end
          if (out_data_o.violations != want.violations) begin
            $error("violations: expected %0d, got %0d", want.violations,
                   out_data_o.violations);
            fail_count++;
          end
          if (out_data_o.disabled != want.disabled) begin
            $error("disabled: expected %0d, got %0d", want.disabled, out_data_o.disabled);
            fail_count++;
          end
          if (want.status <= ST_PRIVACY) status_seen[want.status]++;
          results_checked++;
        end
      end
      // one long hold-off so the skid fills and the input stalls
      if (!hold_done && results_checked >= 30) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct());
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // reset, stimulus phases and end of run
  initial begin
    int unsigned r;
    logic [7:0]  pres;
    hunt_pos     = 0;
    cur_presence = PR_NO_SENSOR;
    cur_conf     = '0;
    frame_total  = '0;
    viol_seen    = 1'b0;
    rx_disabled  = 1'b0;
    foreach (frame_buf[i]) frame_buf[i] = '0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: timeout while hunting
    push_rx(KIND_TIMEOUT, 8'hFF);
    // timeout right after the first sync byte keeps the hunt, then a sync restart
    push_rx(KIND_BYTE, SYNC0);
    push_rx(KIND_TIMEOUT, 8'h00);
    queue_frame(TYPE_PRESENCE, 8'hFE, PRES_PRESENT, 8'hFF, 1'b0);
    // timeout while capturing drops the partial frame
    push_rx(KIND_BYTE, SYNC0);
    push_rx(KIND_BYTE, SYNC1);
    push_rx(KIND_BYTE, TYPE_PRESENCE);
    push_rx(KIND_TIMEOUT, 8'h5A);
    // wrong type with the vital flag set, then a checksum error
    queue_frame(8'h00, 8'hFF, PRES_ABSENT, 8'h00, 1'b0);
    queue_frame(TYPE_PRESENCE, 8'h01, PRES_ABSENT, 8'h80, 1'b1);
    drain();

    // random: mostly well-formed frames, some broken, some noise
    queued_items = 0;
    while (queued_items < RandomItems) begin
      r = $urandom_range(99);
      if (r < 70) begin
        case ($urandom_range(3))
          0: pres = PRES_ABSENT;
          1: pres = PRES_PRESENT;
          default: pres = 8'($urandom);
        endcase
        queue_frame(($urandom_range(9) != 0) ? TYPE_PRESENCE : 8'($urandom),
                    8'($urandom) & 8'hFE, pres, 8'($urandom),
                    ($urandom_range(99) < 15));
      end else if (r < 80) begin
        push_rx(KIND_BYTE, SYNC0);
        push_rx(KIND_BYTE, SYNC1);
        repeat ($urandom_range(FRAME_BYTES - 3)) push_rx(KIND_BYTE, 8'($urandom));
        push_rx(KIND_TIMEOUT, 8'($urandom));
      end else if (r < 92) begin
        repeat ($urandom_range(6, 1)) push_rx(KIND_BYTE, 8'($urandom));
        if ($urandom_range(1)) push_rx(KIND_TIMEOUT, 8'($urandom));
      end else begin
        push_rx(KIND_TIMEOUT, 8'($urandom));
      end
      // sender pauses midway until all results are in
      if (queued_items >= RandomItems / 2 && queued_items < RandomItems / 2 + 10) drain();
    end
    drain();

    // privacy violation latches the disable; later input produces nothing
    queue_frame(TYPE_PRESENCE, 8'($urandom) | 8'h01, PRES_PRESENT, 8'($urandom), 1'b0);
    queue_frame(TYPE_PRESENCE, 8'h00, PRES_PRESENT, 8'h42, 1'b0);
    push_rx(KIND_TIMEOUT, 8'h00);
    queue_frame(TYPE_PRESENCE, 8'h00, PRES_ABSENT, 8'h10, 1'b0);
    drain();
    repeat (10) @(posedge clk_i);

    $display("run: %0d input transactions (%0d timeouts), %0d results checked",
             in_accepted, timeouts_sent, results_checked);
    $display("statuses: accepted %0d, checksum %0d, bad type %0d, privacy %0d; hold-off %0d",
             status_seen[ST_ACCEPTED], status_seen[ST_CHECKSUM], status_seen[ST_BAD_TYPE],
             status_seen[ST_PRIVACY], hold_done);
    if (fail_count == 0 && frame_results_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/pfr_pkg.sv
rtl/presence_frame_receiver.sv
bench/presence_frame_receiver_tb.sv
